### sv/ddms_pkg.sv
// shared constants for the maximum-depth disk splatter
package ddms_pkg;

  localparam int unsigned IMAGE_SIDE   = 64;
  localparam int unsigned WINDOW_REACH = 5;

  localparam int unsigned WIN_N     = 2 * WINDOW_REACH + 1;
  localparam int unsigned WIN_W     = $clog2(WIN_N);
  localparam int unsigned OFF_W     = WIN_W + 1;
  localparam int unsigned MEM_DEPTH = IMAGE_SIDE * IMAGE_SIDE;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned CTR_W     = $clog2(IMAGE_SIDE + 1);
  localparam int unsigned RC_W      = CTR_W + 2;
  localparam int unsigned LOC_W     = $clog2(IMAGE_SIDE);

  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned RAD_W   = 7;
  localparam int unsigned RSQ_W   = 2 * RAD_W;

  localparam int unsigned FRAC_SHIFT  = 16;
  localparam int unsigned LIMIT_SHIFT = 24;
  localparam int unsigned POS_W       = COORD_W + CTR_W;
  localparam int unsigned FRAC_W      = 18;
  localparam int unsigned EX_W        = OFF_W + 17;
  localparam int unsigned SQ_W        = 2 * EX_W;
  localparam int unsigned DIST_W      = SQ_W + 1;

  localparam int unsigned HALF_Q16     = 32768;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 7'd32;

  localparam logic OP_SPLAT = 1'b0;
  localparam logic OP_READ  = 1'b1;

endpackage

### sv/depth_disk_max_splatter.sv
// maximum-depth disk splatter: windowed read-modify-write over a 64 by 64 depth memory
// a splat is accepted in idle, then steps through 121 window pixels at one memory access each,
// then drains the last write; the one read per cycle on the depth memory paces the window
// a read and clear reads the memory on acceptance and registers its result, clearing an in-image
// pixel, once the output is free; a splat may be accepted while a result still waits on the output
// after reset the memory is cleared in a sweep over all 4096 addresses while no item is accepted
module depth_disk_max_splatter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ddms_pkg::RAD_W-1:0]     cfg_radius_sixteenths_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [ddms_pkg::COORD_W-1:0]   x_pos_i,
  input  logic [ddms_pkg::COORD_W-1:0]   z_pos_i,
  input  logic [ddms_pkg::DEPTH_W-1:0]   depth_value_i,
  input  logic [ddms_pkg::IDX_W-1:0]     read_row_i,
  input  logic [ddms_pkg::IDX_W-1:0]     read_col_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ddms_pkg::DEPTH_W-1:0]   pixel_depth_o
);
  import ddms_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SPLAT = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [RAD_W-1:0]   radius_q;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [WIN_W-1:0]   dr_q, dr_d, dc_q, dc_d;

  logic [CTR_W-1:0]         centre_x_q, centre_z_q;
  logic signed [FRAC_W-1:0] frac_x_q, frac_z_q;
  logic [DEPTH_W-1:0]       depth_q;
  logic [DIST_W-1:0]        limit_q;
  logic [ADDR_W-1:0]        rd_addr_q;
  logic                     read_in_q;

  logic                     s1_valid_q, s1_valid_d;
  logic [ADDR_W-1:0]        s1_addr_q;
  logic [SQ_W-1:0]          sqx_q, sqz_q;

  logic                     out_valid_q, out_valid_d;
  logic [DEPTH_W-1:0]       pixel_depth_q, pixel_depth_d;

  logic [DEPTH_W-1:0] mem [MEM_DEPTH];
  logic [DEPTH_W-1:0] mem_rdata_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [DEPTH_W-1:0] mem_wdata;

  logic in_fire, out_free, hit;

  // centre rounding on acceptance
  logic [POS_W-1:0]         pos_x, pos_z, rnd_x, rnd_z;
  logic [CTR_W-1:0]         centre_x, centre_z;
  logic signed [FRAC_W-1:0] frac_x, frac_z;
  logic [RSQ_W-1:0]         rsq;
  logic                     read_in;
  logic [ADDR_W-1:0]        read_addr;

  // window pixel
  logic signed [OFF_W-1:0] dr_off, dc_off;
  logic signed [RC_W-1:0]  row_s, col_s;
  logic                    in_image;
  logic signed [EX_W-1:0]  ex, ez;
  logic signed [SQ_W-1:0]  sqx, sqz;
  logic [ADDR_W-1:0]       pix_addr;
  logic [DIST_W-1:0]       dist_sq;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_fire       = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign pixel_depth_o = pixel_depth_q;

  assign pos_x    = POS_W'(x_pos_i) * POS_W'(IMAGE_SIDE);
  assign pos_z    = POS_W'(z_pos_i) * POS_W'(IMAGE_SIDE);
  assign rnd_x    = pos_x + POS_W'(HALF_Q16);
  assign rnd_z    = pos_z + POS_W'(HALF_Q16);
  assign centre_x = rnd_x[POS_W-1:FRAC_SHIFT];
  assign centre_z = rnd_z[POS_W-1:FRAC_SHIFT];
  assign frac_x   = FRAC_W'($signed({1'b0, centre_x, 16'b0}) - $signed({1'b0, pos_x}));
  assign frac_z   = FRAC_W'($signed({1'b0, centre_z, 16'b0}) - $signed({1'b0, pos_z}));
  assign rsq      = RSQ_W'(radius_q) * RSQ_W'(radius_q);

  assign read_in   = (32'(read_row_i) < IMAGE_SIDE) && (32'(read_col_i) < IMAGE_SIDE);
  assign read_addr = ADDR_W'(read_row_i) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(read_col_i);

  assign dr_off = $signed({1'b0, dr_q}) - $signed(OFF_W'(WINDOW_REACH));
  assign dc_off = $signed({1'b0, dc_q}) - $signed(OFF_W'(WINDOW_REACH));
  assign row_s  = $signed({2'b0, centre_z_q}) + RC_W'(dr_off);
  assign col_s  = $signed({2'b0, centre_x_q}) + RC_W'(dc_off);
  assign in_image = !row_s[RC_W-1] && (row_s < $signed(RC_W'(IMAGE_SIDE))) &&
                    !col_s[RC_W-1] && (col_s < $signed(RC_W'(IMAGE_SIDE)));
  assign ex     = (EX_W'(dc_off) <<< FRAC_SHIFT) + EX_W'(frac_x_q);
  assign ez     = (EX_W'(dr_off) <<< FRAC_SHIFT) + EX_W'(frac_z_q);
  assign sqx    = ex * ex;
  assign sqz    = ez * ez;
  assign pix_addr = ADDR_W'(row_s[LOC_W-1:0]) * ADDR_W'(IMAGE_SIDE) +
                    ADDR_W'(col_s[LOC_W-1:0]);

  assign dist_sq = DIST_W'(sqx_q) + DIST_W'(sqz_q);
  assign hit     = s1_valid_q && (dist_sq <= limit_q) && (depth_q > mem_rdata_q);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    dr_d          = dr_q;
    dc_d          = dc_q;
    s1_valid_d    = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    pixel_depth_d = pixel_depth_q;
    mem_we        = 1'b0;
    mem_waddr     = s1_addr_q;
    mem_wdata     = depth_q;
    mem_re        = 1'b0;
    mem_raddr     = pix_addr;
    if (hit) begin
      mem_we = 1'b1;
    end
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          dr_d = '0;
          dc_d = '0;
          if (op_i == OP_SPLAT) begin
            state_d = ST_SPLAT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = read_addr;
            state_d   = ST_READ;
          end
        end
      end
      ST_SPLAT: begin
        mem_re     = 1'b1;
        s1_valid_d = in_image;
        if (dc_q == WIN_W'(WIN_N - 1)) begin
          dc_d = '0;
          dr_d = dr_q + 1'b1;
          if (dr_q == WIN_W'(WIN_N - 1)) begin
            state_d = ST_DRAIN;
          end
        end else begin
          dc_d = dc_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          pixel_depth_d = read_in_q ? mem_rdata_q : '0;
          mem_we        = read_in_q;
          mem_waddr     = rd_addr_q;
          mem_wdata     = '0;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      radius_q    <= RADIUS_RESET;
      clr_q       <= '0;
      dr_q        <= '0;
      dc_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      dr_q        <= dr_d;
      dc_q        <= dc_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_radius_sixteenths_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_depth_q <= pixel_depth_d;
    s1_addr_q     <= pix_addr;
    sqx_q         <= SQ_W'(sqx);
    sqz_q         <= SQ_W'(sqz);
    if (in_fire) begin
      centre_x_q <= centre_x;
      centre_z_q <= centre_z;
      frac_x_q   <= frac_x;
      frac_z_q   <= frac_z;
      depth_q    <= depth_value_i;
      limit_q    <= DIST_W'(rsq) << LIMIT_SHIFT;
      rd_addr_q  <= read_addr;
      read_in_q  <= read_in;
    end
  end

  // depth memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == OP_SPLAT) |=> (state_q == ST_SPLAT && dr_q == '0 && dc_q == '0))
    else $error("splat did not start at window origin");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_READ))
    else $error("result raised outside a read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(state_q == ST_SPLAT))
    else $error("compare stage valid without a window pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_q != ADDR_W'(MEM_DEPTH - 1)) |=> (state_q == ST_CLEAR))
    else $error("clear sweep left early");
`endif

endmodule
